// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define GDS_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// expression must never be true out of reset
`define GDS_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define GDS_ASSERT(label, clk, rstn, prop)
`define GDS_NEVER(label, clk, rstn, expr)

`endif

`endif

// File: src/gds_pkg.sv
`timescale 1ns / 1ps

package gds_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int CENTER_W   = 14;
  localparam int BOX_W      = 9;
  localparam int R2_SHIFT   = 2 * (FRAC_BITS + 8) - 5;
  localparam int TAB_AW_MAX = 13;

  localparam logic [31:0] EXP_STEP_Q32 = 32'd4228380000;

  localparam logic [1:0] OP_SPLAT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] REG_SIZE_X   = 3'd0;
  localparam logic [2:0] REG_SIZE_Y   = 3'd1;
  localparam logic [2:0] REG_SIZE_Z   = 3'd2;
  localparam logic [2:0] REG_INV_SDEV = 3'd3;
  localparam logic [2:0] REG_REACH    = 3'd4;

  typedef struct packed {
    logic                  we;
    logic [TAB_AW_MAX-1:0] addr;
    logic [15:0]           data;
  } tab_wr_t;

  // first voxel index at or above c - reach
  function automatic logic [BOX_W-1:0] box_lo(input logic [CENTER_W-1:0] c,
                                               input logic [CENTER_W-1:0] rch);
    logic [CENTER_W:0] s;
    s = 15'(c) - 15'(rch) + 15'((1 << FRAC_BITS) - 1);
    if (c <= rch) begin
      return '0;
    end
    return BOX_W'(s >> FRAC_BITS);
  endfunction

  // last voxel index at or below c + reach, clipped to n - 1
  function automatic logic [BOX_W-1:0] box_hi(input logic [CENTER_W-1:0] c,
                                               input logic [CENTER_W-1:0] rch,
                                               input logic [BOX_W-1:0]    n);
    logic [CENTER_W:0] s;
    logic [BOX_W-1:0]  h;
    s = 15'(c) + 15'(rch);
    h = BOX_W'(s >> FRAC_BITS);
    if (h >= n) begin
      return n - BOX_W'(1);
    end
    return h;
  endfunction

endpackage

// File: src/gaussian_density_splat.sv
`timescale 1ns / 1ps
// splat: a setup state, then one voxel a cycle over the clipped box, then a
//   drain state until the read-modify-write pipeline is empty
// read: waits for a free result register; clear: one grid word a cycle
// one request at a time; throughput is set by the single grid write port
// reset: synchronous, active low; after reset a clearing pass over the whole grid
//   (and the falloff table build) runs with in_stall high

`include "assert_macros.svh"

module gaussian_density_splat import gds_pkg::*; #(
  parameter int GRID_DIM    = 64,
  parameter int EXP_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [13:0] in_center_x,
  input  logic [13:0] in_center_y,
  input  logic [13:0] in_center_z,
  input  logic [7:0]  in_weight,
  input  logic [5:0]  in_voxel_x,
  input  logic [5:0]  in_voxel_y,
  input  logic [5:0]  in_voxel_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int GA    = 3 * AW;
  localparam int DEPTH = 1 << GA;
  localparam int TW    = $clog2(EXP_ENTRIES);

  // controller states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_SPLAT  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_RD     = 3'd5;
  localparam logic [2:0] ST_RDLOAD = 3'd6;

  // absolute offset from centre along one axis, scaled by inv_sdev
  function automatic logic [31:0] axis_u(input logic [AW-1:0] idx,
                                         input logic [13:0]   c,
                                         input logic [15:0]   isd);
    logic [17:0] d;
    logic [17:0] nd;
    logic [15:0] m;
    d  = 18'(idx) << FRAC_BITS;
    d  = d - 18'(c);
    nd = -d;
    m  = d[17] ? nd[15:0] : d[15:0];
    return 32'(m) * 32'(isd);
  endfunction

  logic [2:0]  state_r, state_nxt;

  // configuration registers
  logic [6:0]  size_x_r, size_y_r, size_z_r;
  logic [15:0] inv_sdev_r;
  logic [13:0] reach_r;

  // latched request
  logic [13:0] cx_r, cy_r, cz_r;
  logic [7:0]  w_r;
  logic [GA-1:0] rd_addr_r;
  logic          rd_in_r;

  // box bounds and the voxel walk
  logic [AW-1:0] lo_x_r, lo_y_r, hi_x_r, hi_y_r, hi_z_r;
  logic [AW-1:0] i_r, j_r, k_r;
  logic [BOX_W-1:0] nx, ny, nz, bx0, bx1, by0, by1, bz0, bz1;
  logic             box_empty;

  // clearing pass
  logic [GA-1:0] clr_r;
  logic          clr_last;

  // splat pipeline: scale, square, then read-modify-write
  logic          p1_v_r, p2_v_r, p3_v_r;
  logic [GA-1:0] p1_addr_r, p2_addr_r, p3_addr_r;
  logic [31:0]   ux_r, uy_r, uz_r;
  logic [61:0]   sqx_r, sqy_r, sqz_r;
  logic          p2_far_r;
  logic [63:0]   r2_sum;
  logic [63:0]   r2_idx;
  logic          p2_hit;
  logic          walk_last;

  // memories
  logic          grid_we;
  logic [GA-1:0] grid_waddr, grid_raddr;
  logic [31:0]   grid_wdata, grid_rdata;
  logic [TW-1:0] tab_raddr;
  logic [15:0]   tab_rdata;
  tab_wr_t       tab_wr;
  logic          tab_done;
  logic [32:0]   acc;

  // output register
  logic          out_valid_r;
  logic [31:0]   out_data_r;

  logic in_acc;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r   <= 7'd64;
      size_y_r   <= 7'd64;
      size_z_r   <= 7'd64;
      inv_sdev_r <= 16'd380;
      reach_r    <= 14'd864;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIZE_X:   size_x_r   <= cfg_data[6:0];
        REG_SIZE_Y:   size_y_r   <= cfg_data[6:0];
        REG_SIZE_Z:   size_z_r   <= cfg_data[6:0];
        REG_INV_SDEV: inv_sdev_r <= cfg_data;
        REG_REACH:    reach_r    <= cfg_data[13:0];
        default: begin
        end
      endcase
    end
  end

  // clip each axis to min(size, GRID_DIM) voxels
  assign nx = (BOX_W'(size_x_r) > BOX_W'(GRID_DIM)) ? BOX_W'(GRID_DIM) : BOX_W'(size_x_r);
  assign ny = (BOX_W'(size_y_r) > BOX_W'(GRID_DIM)) ? BOX_W'(GRID_DIM) : BOX_W'(size_y_r);
  assign nz = (BOX_W'(size_z_r) > BOX_W'(GRID_DIM)) ? BOX_W'(GRID_DIM) : BOX_W'(size_z_r);
  assign bx0 = box_lo(cx_r, reach_r);
  assign by0 = box_lo(cy_r, reach_r);
  assign bz0 = box_lo(cz_r, reach_r);
  assign bx1 = box_hi(cx_r, reach_r, nx);
  assign by1 = box_hi(cy_r, reach_r, ny);
  assign bz1 = box_hi(cz_r, reach_r, nz);
  assign box_empty = (inv_sdev_r == '0) || (nx == '0) || (ny == '0) || (nz == '0) ||
                     (bx0 > bx1) || (by0 > by1) || (bz0 > bz1);

  assign walk_last = (i_r == hi_x_r) && (j_r == hi_y_r) && (k_r == hi_z_r);
  assign clr_last  = (clr_r == {GA{1'b1}});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_last && tab_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_opcode)
            OP_SPLAT: state_nxt = ST_SETUP;
            OP_READ:  state_nxt = ST_RD;
            OP_CLEAR: state_nxt = ST_CLEAR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SETUP:  state_nxt = box_empty ? ST_IDLE : ST_SPLAT;
      ST_SPLAT:  state_nxt = walk_last ? ST_DRAIN : ST_SPLAT;
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r && !p3_v_r) begin
          state_nxt = ST_IDLE;
        end
      end
      // wait until the output register is free before reading
      ST_RD:     state_nxt = (!out_valid_r || !out_stall) ? ST_RDLOAD : ST_RD;
      ST_RDLOAD: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR && !clr_last) begin
        clr_r <= clr_r + GA'(1);
      end else if (state_r == ST_IDLE) begin
        clr_r <= '0;
      end
    end
  end

  // request latch, box bounds and voxel walk
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cx_r      <= in_center_x;
      cy_r      <= in_center_y;
      cz_r      <= in_center_z;
      w_r       <= in_weight;
      rd_addr_r <= {AW'(in_voxel_z), AW'(in_voxel_y), AW'(in_voxel_x)};
      rd_in_r   <= (BOX_W'(in_voxel_x) < BOX_W'(GRID_DIM)) &&
                   (BOX_W'(in_voxel_y) < BOX_W'(GRID_DIM)) &&
                   (BOX_W'(in_voxel_z) < BOX_W'(GRID_DIM));
    end
    if (state_r == ST_SETUP) begin
      lo_x_r <= AW'(bx0);
      lo_y_r <= AW'(by0);
      hi_x_r <= AW'(bx1);
      hi_y_r <= AW'(by1);
      hi_z_r <= AW'(bz1);
      i_r    <= AW'(bx0);
      j_r    <= AW'(by0);
      k_r    <= AW'(bz0);
    end else if (state_r == ST_SPLAT) begin
      if (i_r != hi_x_r) begin
        i_r <= i_r + AW'(1);
      end else begin
        i_r <= lo_x_r;
        if (j_r != hi_y_r) begin
          j_r <= j_r + AW'(1);
        end else begin
          j_r <= lo_y_r;
          k_r <= k_r + AW'(1);
        end
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      p1_v_r <= (state_r == ST_SPLAT);
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r && p2_hit;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    p1_addr_r <= {k_r, j_r, i_r};
    ux_r      <= axis_u(i_r, cx_r, inv_sdev_r);
    uy_r      <= axis_u(j_r, cy_r, inv_sdev_r);
    uz_r      <= axis_u(k_r, cz_r, inv_sdev_r);
    p2_addr_r <= p1_addr_r;
    sqx_r     <= 62'(ux_r[30:0]) * 62'(ux_r[30:0]);
    sqy_r     <= 62'(uy_r[30:0]) * 62'(uy_r[30:0]);
    sqz_r     <= 62'(uz_r[30:0]) * 62'(uz_r[30:0]);
    p2_far_r  <= ux_r[31] | uy_r[31] | uz_r[31];
    p3_addr_r <= p2_addr_r;
  end

  // squared radius to falloff table index; far voxels add nothing
  assign r2_sum = 64'(sqx_r) + 64'(sqy_r) + 64'(sqz_r);
  assign r2_idx = r2_sum >> R2_SHIFT;
  assign p2_hit = !p2_far_r && (r2_idx < 64'(EXP_ENTRIES));
  assign tab_raddr = r2_idx[TW-1:0];

  // saturating accumulate of weight * falloff
  assign acc = 33'(grid_rdata) + 33'(24'(w_r) * 24'(tab_rdata));

  always_comb begin
    if (state_r == ST_CLEAR) begin
      grid_we    = 1'b1;
      grid_waddr = clr_r;
      grid_wdata = '0;
    end else begin
      grid_we    = p3_v_r;
      grid_waddr = p3_addr_r;
      grid_wdata = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
    end
  end

  assign grid_raddr = (state_r == ST_RD) ? rd_addr_r : p2_addr_r;

  gds_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  gds_tab_fill #(
    .EXP_ENTRIES (EXP_ENTRIES)
  ) u_tab_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (tab_wr),
    .done  (tab_done)
  );

  gds_ram #(
    .WIDTH (16),
    .DEPTH (EXP_ENTRIES)
  ) u_falloff (
    .clk   (clk),
    .we    (tab_wr.we),
    .waddr (tab_wr.addr[TW-1:0]),
    .wdata (tab_wr.data),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RDLOAD) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RDLOAD) begin
      out_data_r <= rd_in_r ? grid_rdata : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;

  // a request is only taken with the splat pipeline empty
  `GDS_NEVER(a_acc_busy, clk, rst_n, in_acc && (p1_v_r || p2_v_r || p3_v_r))
  // a result appears only after a read has loaded it
  `GDS_ASSERT(a_out_src, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_RDLOAD))
  // the accumulate write never overlaps the clearing pass
  `GDS_NEVER(a_clr_rmw, clk, rst_n, (state_r == ST_CLEAR) && p3_v_r)
  // the grid is only written while a clear or splat is in progress
  `GDS_NEVER(a_idle_wr, clk, rst_n, (state_r == ST_IDLE) && grid_we)

endmodule

// File: src/gds_ram.sv
`timescale 1ns / 1ps

module gds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/gds_tab_fill.sv
`timescale 1ns / 1ps

module gds_tab_fill import gds_pkg::*; #(
  parameter int EXP_ENTRIES = 1024
) (
  input  logic    clk,
  input  logic    rst_n,
  output tab_wr_t wr,
  output logic    done
);

  localparam int CW = $clog2(EXP_ENTRIES + 1);

  logic [CW-1:0] n_r;
  logic [32:0]   v_r;
  logic [63:0]   prod_r;
  logic          ph_r;
  logic          done_r;
  logic [17:0]   e;

  // per entry: a multiply phase, then a round and shift phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      v_r    <= 33'h1_0000_0000;
      ph_r   <= 1'b0;
      done_r <= 1'b0;
    end else if (!done_r) begin
      if (!ph_r) begin
        prod_r <= 64'(v_r[31:0]) * 64'(EXP_STEP_Q32);
        ph_r   <= 1'b1;
      end else begin
        v_r  <= v_r[32] ? 33'(EXP_STEP_Q32) : 33'((prod_r + 64'h8000_0000) >> 32);
        n_r  <= n_r + CW'(1);
        ph_r <= 1'b0;
        if (n_r == CW'(EXP_ENTRIES - 1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign e       = 18'((34'(v_r) + 34'h8000) >> 16);
  assign wr.we   = !done_r && !ph_r;
  assign wr.addr = TAB_AW_MAX'(n_r);
  assign wr.data = (e > 18'hFFFF) ? 16'hFFFF : e[15:0];
  assign done    = done_r;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench import gds_pkg::*;;

  // opcode with no meaning, the block drops it
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int DIM = 64;
  localparam int TAB_LEN = 1024;

  // mirror of the grid and registers, plus the queue of pending voxel reads
  class density_scoreboard;
    bit [31:0] grid [0:DIM*DIM*DIM-1];
    bit [15:0] falloff [0:TAB_LEN-1];
    int unsigned size_x, size_y, size_z, inv_sdev, reach;
    bit [31:0] pending_reads [$];
    int errors;

    function new();
      bit [63:0] v;
      bit [63:0] e;
      v = 64'd1 << 32;
      for (int n = 0; n < TAB_LEN; n++) begin
        e = (v + 64'd32768) >> 16;
        falloff[n] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
        v = (v * 64'd4228380000 + (64'd1 << 31)) >> 32;
      end
      foreach (grid[i]) grid[i] = '0;
      size_x = 64; size_y = 64; size_z = 64;
      inv_sdev = 380; reach = 864;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_SIZE_X:   size_x = data[6:0];
        REG_SIZE_Y:   size_y = data[6:0];
        REG_SIZE_Z:   size_z = data[6:0];
        REG_INV_SDEV: inv_sdev = data;
        REG_REACH:    reach = data[13:0];
        default: ;
      endcase
    endfunction

    function bit axis_span(int unsigned c, int unsigned sz, output int unsigned lo,
                           output int unsigned hi);
      int unsigned n;
      n = (sz > DIM) ? DIM : sz;
      lo = 0;
      hi = 0;
      if (n == 0) return 0;
      lo = (c <= reach) ? 0 : (c - reach + 255) >> 8;
      hi = (c + reach) >> 8;
      if (hi >= n) hi = n - 1;
      return lo <= hi;
    endfunction

    function bit [63:0] axis_term(int unsigned idx, int unsigned c, inout bit far);
      longint d;
      bit [63:0] u;
      d = longint'(idx << 8) - longint'(c);
      u = 64'(d < 0 ? -d : d) * 64'(inv_sdev);
      if (u >= (64'd1 << 31)) begin
        far = 1;
        return 0;
      end
      return u * u;
    endfunction

    function void splat_atom(int unsigned cx, int unsigned cy, int unsigned cz,
                             int unsigned w);
      int unsigned x0, x1, y0, y1, z0, z1, at;
      bit far;
      bit [63:0] r2, t, sum;
      if (inv_sdev == 0) return;
      if (!axis_span(cx, size_x, x0, x1)) return;
      if (!axis_span(cy, size_y, y0, y1)) return;
      if (!axis_span(cz, size_z, z0, z1)) return;
      for (int unsigned k = z0; k <= z1; k++)
        for (int unsigned j = y0; j <= y1; j++)
          for (int unsigned i = x0; i <= x1; i++) begin
            far = 0;
            r2 = axis_term(i, cx, far) + axis_term(j, cy, far) + axis_term(k, cz, far);
            t = r2 >> R2_SHIFT;
            if (!far && t < TAB_LEN) begin
              at = (k * DIM + j) * DIM + i;
              sum = 64'(grid[at]) + 64'(w) * 64'(falloff[t]);
              grid[at] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            end
          end
    endfunction

    function void note_request(logic [1:0] op, int unsigned cx, int unsigned cy,
                               int unsigned cz, int unsigned w, int unsigned vx,
                               int unsigned vy, int unsigned vz);
      case (op)
        OP_SPLAT: splat_atom(cx, cy, cz, w);
        OP_READ:  pending_reads.push_back(grid[(vz * DIM + vy) * DIM + vx]);
        OP_CLEAR: foreach (grid[i]) grid[i] = '0;
        default: ;
      endcase
    endfunction

    function void check_read(logic [31:0] got);
      bit [31:0] want;
      if (pending_reads.size() == 0) begin
        $error("read_value: no read pending, actual %h", got);
        errors++;
        return;
      end
      want = pending_reads.pop_front();
      if (got !== want) begin
        $error("read_value: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [13:0] in_center_x, in_center_y, in_center_z;
  logic [7:0]  in_weight;
  logic [5:0]  in_voxel_x, in_voxel_y, in_voxel_z;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_read_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  density_scoreboard sb;

  // idling pattern: 0 none, 1 sender gaps, 2 receiver stalls, 3 both lightly
  int idle_mode;
  // toggled by the stimulus to ask the receiver for a long hold-off
  logic hold_toggle;
  int unsigned last_cx, last_cy, last_cz;

  gaussian_density_splat u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_center_x   (in_center_x),
    .in_center_y   (in_center_y),
    .in_center_z   (in_center_z),
    .in_weight     (in_weight),
    .in_voxel_x    (in_voxel_x),
    .in_voxel_y    (in_voxel_y),
    .in_voxel_z    (in_voxel_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // result side: check every accepted read, then pick next cycle's stall
  initial begin
    int hold_left;
    logic seen_toggle;
    hold_left = 0;
    seen_toggle = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_read(out_read_value);
      if (hold_toggle !== seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left = 2000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (idle_mode)
          2: out_stall <= ($urandom_range(99) < 49);
          3: out_stall <= ($urandom_range(99) < 6);
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // hard stop, well past the slowest legal run
  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one request on the input channel; called at a rising edge, returns at one
  task automatic send_request(logic [1:0] op, int unsigned cx, int unsigned cy,
                              int unsigned cz, int unsigned w, int unsigned vx,
                              int unsigned vy, int unsigned vz);
    in_opcode   <= op;
    in_center_x <= cx[13:0];
    in_center_y <= cy[13:0];
    in_center_z <= cz[13:0];
    in_weight   <= w[7:0];
    in_voxel_x  <= vx[5:0];
    in_voxel_y  <= vy[5:0];
    in_voxel_z  <= vz[5:0];
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, cx[13:0], cy[13:0], cz[13:0], w[7:0], vx[5:0], vy[5:0], vz[5:0]);
    if (op == OP_SPLAT) begin
      last_cx = cx[13:0];
      last_cy = cy[13:0];
      last_cz = cz[13:0];
    end
    // sender gaps, drawn per cycle
    if ((idle_mode == 1 && $urandom_range(99) < 49) ||
        (idle_mode == 3 && $urandom_range(99) < 6)) begin
      in_valid <= 1'b0;
      do @(posedge clk);
      while ((idle_mode == 1 && $urandom_range(99) < 49) ||
             (idle_mode == 3 && $urandom_range(99) < 6));
    end
  endtask

  task automatic splat(int unsigned cx, int unsigned cy, int unsigned cz, int unsigned w);
    send_request(OP_SPLAT, cx, cy, cz, w, 0, 0, 0);
  endtask

  task automatic read_voxel(int unsigned vx, int unsigned vy, int unsigned vz);
    send_request(OP_READ, 0, 0, 0, 0, vx, vy, vz);
  endtask

  // a read queues behind any splat still running, so its result means idle
  task automatic drain();
    read_voxel($urandom_range(63), $urandom_range(63), $urandom_range(63));
    in_valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned data);
    cfg_index <= idx;
    cfg_data  <= data[15:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data[15:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(int unsigned sx, int unsigned sy, int unsigned sz,
                          int unsigned inv, int unsigned rch);
    drain();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_INV_SDEV, inv);
    write_reg(REG_REACH, rch);
  endtask

  // random mix: splats mostly inside the grid in use, reads mostly near the last atom
  task automatic random_phase(int n, int mode);
    int unsigned span, r;
    idle_mode = mode;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      span = (sb.size_x > DIM || sb.size_x == 0) ? DIM : sb.size_x;
      if (r < 55) begin
        if ($urandom_range(9) == 0)
          splat($urandom_range(16383), $urandom_range(16383), $urandom_range(16383),
                $urandom_range(255));
        else
          splat($urandom_range(span * 256 - 1), $urandom_range(span * 256 - 1),
                $urandom_range(span * 256 - 1), $urandom_range(255));
      end else if (r < 97) begin
        if (r < 85)
          read_voxel((last_cx >> 8) + $urandom_range(2) - 1,
                     (last_cy >> 8) + $urandom_range(2) - 1,
                     (last_cz >> 8) + $urandom_range(2) - 1);
        else
          read_voxel($urandom_range(63), $urandom_range(63), $urandom_range(63));
      end else begin
        send_request(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
      end
    end
  endtask

  initial begin
    int unsigned sat_x, sat_y, sat_z;
    sb = new();
    idle_mode = 0;
    hold_toggle <= 1'b0;
    last_cx = 0; last_cy = 0; last_cz = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_SPLAT;
    in_center_x <= '0;
    in_center_y <= '0;
    in_center_z <= '0;
    in_weight   <= '0;
    in_voxel_x  <= '0;
    in_voxel_y  <= '0;
    in_voxel_z  <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_SIZE_X;
    cfg_data    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings first, grid edges, the ignored opcode, a clear
    splat(32'h0A80, 32'h1440, 32'h1E00, 255);
    read_voxel(10, 20, 30);
    read_voxel(11, 21, 31);
    splat(16383, 16383, 16383, 200);
    splat(0, 0, 0, 1);
    splat(32'h1000, 32'h1000, 32'h1000, 0);
    send_request(OP_NONE, 16383, 16383, 16383, 255, 63, 63, 63);
    read_voxel(63, 63, 63);
    read_voxel(0, 0, 0);
    send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    read_voxel(10, 20, 30);

    // zero inv_sdev leaves the grid alone
    set_regs(64, 64, 64, 0, 864);
    splat(32'h0500, 32'h0500, 32'h0500, 255);
    read_voxel(5, 5, 5);
    // sharpest width and empty box from zero reach off the voxel grid
    set_regs(64, 64, 64, 65535, 0);
    splat(32'h0500, 32'h0500, 32'h0500, 255);
    splat(32'h0680, 32'h0600, 32'h0600, 255);
    read_voxel(5, 5, 5);
    // zero size, then widest reach clipped by a tiny grid
    set_regs(0, 64, 64, 380, 864);
    splat(32'h0200, 32'h0200, 32'h0200, 255);
    set_regs(4, 4, 4, 1, 16383);
    splat(32'h0180, 32'h0100, 32'h0200, 255);
    read_voxel(3, 0, 2);
    // oversized size acts as the full grid; single voxel axis
    set_regs(127, 127, 1, 380, 300);
    splat(32'h3F80, 32'h3F80, 32'h0040, 255);
    read_voxel(63, 63, 0);

    // random phases across settings and idling patterns
    for (int p = 0; p < 6; p++) begin
      if (p == 5)
        set_regs($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                 $urandom_range(65535), $urandom_range(16383));
      else
        set_regs($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                 (p == 3) ? $urandom_range(65535) : $urandom_range(64, 1024),
                 $urandom_range(0, 900));
      random_phase(110, p % 4);
    end

    // pile atoms onto one voxel until the sum saturates
    set_regs(64, 64, 64, 380, 0);
    idle_mode = 0;
    sat_x = $urandom_range(63);
    sat_y = $urandom_range(63);
    sat_z = $urandom_range(63);
    for (int i = 0; i < 300; i++) begin
      splat(sat_x << 8, sat_y << 8, sat_z << 8, $urandom_range(240, 255));
      if (i % 40 == 0) read_voxel(sat_x, sat_y, sat_z);
    end
    read_voxel(sat_x, sat_y, sat_z);

    // long receiver hold-off while requests keep coming, so the input backs up
    set_regs(64, 64, 64, 380, 864);
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < 20; i++)
      read_voxel(sat_x, sat_y, $urandom_range(63));
    drain();

    random_phase(60, 0);
    in_valid <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk);
    // a splat may still be running with no result to show for it
    repeat (400) @(posedge clk);

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
